[rtl/core/dtrn_pkg.sv]
// Shared types and constants for the decimated trace ring normalizer.
// Used by the top level and the trace store RAM instance; no dependencies.
package dtrn_pkg;

	localparam int RING_DEPTH   = 64;
	localparam int MAX_SNAPSHOT = 64;
	localparam int HARD_CAP     = 64;
	localparam int SNAP_CAP     = (MAX_SNAPSHOT < HARD_CAP) ? MAX_SNAPSHOT : HARD_CAP;

	localparam int SAMPLE_W = 12;
	localparam int PCT_W    = 7;
	localparam int FACTOR_W = 8;
	localparam int MAXC_W   = 7;
	localparam int PTR_W    = $clog2(RING_DEPTH);
	localparam int FILL_W   = $clog2(RING_DEPTH + 1);
	localparam int CNT_W    = (FILL_W > MAXC_W) ? FILL_W : MAXC_W;
	localparam int NUM_W    = SAMPLE_W + PCT_W;
	localparam int DIV_W    = $clog2(NUM_W + 1);

	localparam logic [SAMPLE_W-1:0] FULL_SCALE = SAMPLE_W'(4095);
	localparam logic [PCT_W-1:0]    PCT_SCALE  = PCT_W'(100);

	typedef enum logic [1:0] {
		ACT_SAMPLE = 2'd0,
		ACT_SNAP   = 2'd1,
		ACT_CLEAR  = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SPAN,
		ST_FETCH,
		ST_LOAD,
		ST_DIV,
		ST_EMIT
	} state_t;

endpackage

[rtl/core/dtrn_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dtrn_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/decimated_trace_ring_normalizer_top.sv]
// Decimated trace ring normalizer: ring store of sensor samples with min/max scaled snapshots.
// Depends on dtrn_pkg and dtrn_ram.
//
// Sample, clear and empty-snapshot transactions are handled in the idle state. A snapshot of n entries
// first scans the ring to find min and max (one RAM read per cycle), then handles each
// entry in turn: RAM read, scale by 100, and a bit-serial restoring divider, then holds
// the result until the output takes it. The input stays stalled until the last result of a
// snapshot is taken. The trace store has no clearing pass; only entries written since the
// last clear are ever read.
module decimated_trace_ring_normalizer_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [dtrn_pkg::FACTOR_W-1:0]  cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     action,
	input  logic [dtrn_pkg::SAMPLE_W-1:0]  sample,
	input  logic [dtrn_pkg::MAXC_W-1:0]    max_count,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [dtrn_pkg::PCT_W-1:0]     percent,
	output logic                           last
);

	localparam int SUM_W = dtrn_pkg::PTR_W + 1;

	dtrn_pkg::state_t state_q, state_d;

	logic [dtrn_pkg::FACTOR_W-1:0] factor_q;
	logic [dtrn_pkg::FACTOR_W-1:0] dec_cnt_q;
	logic [dtrn_pkg::PTR_W-1:0]    wp_q;
	logic [dtrn_pkg::FILL_W-1:0]   fill_q;
	logic [dtrn_pkg::CNT_W-1:0]    n_q;
	logic [dtrn_pkg::CNT_W-1:0]    cnt_q;
	logic [dtrn_pkg::PTR_W-1:0]    base_q;
	logic [dtrn_pkg::PTR_W-1:0]    ptr_q;
	logic [dtrn_pkg::SAMPLE_W-1:0] lo_q;
	logic [dtrn_pkg::SAMPLE_W-1:0] hi_q;
	logic [dtrn_pkg::SAMPLE_W-1:0] span_q;
	logic [dtrn_pkg::SAMPLE_W-1:0] rem_q;
	logic [dtrn_pkg::NUM_W-1:0]    num_q;
	logic [dtrn_pkg::DIV_W-1:0]    div_cnt_q;
	logic                          rdv_s1;

	logic                          in_acc;
	logic                          out_acc;
	logic [dtrn_pkg::FACTOR_W-1:0] factor_eff;
	logic [dtrn_pkg::FACTOR_W-1:0] dec_inc;
	logic                          store_now;
	logic [dtrn_pkg::CNT_W-1:0]    n_fm;
	logic [dtrn_pkg::CNT_W-1:0]    n_in;
	logic [SUM_W-1:0]              base_sum;
	logic [dtrn_pkg::PTR_W-1:0]    base_in;
	logic [dtrn_pkg::PTR_W-1:0]    ptr_inc;
	logic [dtrn_pkg::PTR_W-1:0]    wp_inc;
	logic                          scan_rd;
	logic                          ram_re;
	logic [dtrn_pkg::SAMPLE_W-1:0] ram_rdata;
	logic [dtrn_pkg::SAMPLE_W:0]   rem_sh;
	logic                          q_bit;
	logic [dtrn_pkg::SAMPLE_W:0]   rem_sub;
	logic [dtrn_pkg::SAMPLE_W-1:0] diff;
	logic                          is_last;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// decimation
	assign factor_eff = (factor_q == '0) ? dtrn_pkg::FACTOR_W'(1) : factor_q;
	assign dec_inc    = dec_cnt_q + dtrn_pkg::FACTOR_W'(1);
	assign store_now  = in_acc && (action == dtrn_pkg::ACT_SAMPLE) && (dec_inc >= factor_eff);
	assign wp_inc     = (wp_q == dtrn_pkg::PTR_W'(dtrn_pkg::RING_DEPTH - 1)) ? '0
	                                                                         : wp_q + 1'b1;

	// snapshot length and start
	assign n_fm = (dtrn_pkg::CNT_W'(fill_q) < dtrn_pkg::CNT_W'(max_count))
	            ? dtrn_pkg::CNT_W'(fill_q) : dtrn_pkg::CNT_W'(max_count);
	assign n_in = (n_fm < dtrn_pkg::CNT_W'(dtrn_pkg::SNAP_CAP))
	            ? n_fm : dtrn_pkg::CNT_W'(dtrn_pkg::SNAP_CAP);
	assign base_sum = {1'b0, wp_q} + SUM_W'(dtrn_pkg::RING_DEPTH) - SUM_W'(n_in);
	assign base_in  = (base_sum >= SUM_W'(dtrn_pkg::RING_DEPTH))
	                ? dtrn_pkg::PTR_W'(base_sum - SUM_W'(dtrn_pkg::RING_DEPTH))
	                : dtrn_pkg::PTR_W'(base_sum);
	assign ptr_inc  = (ptr_q == dtrn_pkg::PTR_W'(dtrn_pkg::RING_DEPTH - 1)) ? '0
	                                                                       : ptr_q + 1'b1;

	// divider step, offset from min and last-entry flag
	assign rem_sh  = {rem_q, num_q[dtrn_pkg::NUM_W-1]};
	assign q_bit   = (rem_sh >= {1'b0, span_q});
	assign rem_sub = q_bit ? (rem_sh - {1'b0, span_q}) : rem_sh;
	assign diff    = ram_rdata - lo_q;
	assign is_last = ((cnt_q + dtrn_pkg::CNT_W'(1)) == n_q);

	dtrn_ram #(
		.WIDTH(dtrn_pkg::SAMPLE_W),
		.DEPTH(dtrn_pkg::RING_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (store_now),
		.waddr(wp_q),
		.wdata(sample),
		.re   (ram_re),
		.raddr(ptr_q),
		.rdata(ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dtrn_pkg::ST_IDLE: begin
				if (in_acc && (action == dtrn_pkg::ACT_SNAP) && (n_in != '0)) begin
					state_d = dtrn_pkg::ST_SCAN;
				end
			end
			dtrn_pkg::ST_SCAN: begin
				if ((cnt_q == n_q) && !rdv_s1) begin
					state_d = dtrn_pkg::ST_SPAN;
				end
			end
			dtrn_pkg::ST_SPAN:  state_d = dtrn_pkg::ST_FETCH;
			dtrn_pkg::ST_FETCH: state_d = dtrn_pkg::ST_LOAD;
			dtrn_pkg::ST_LOAD:  state_d = dtrn_pkg::ST_DIV;
			dtrn_pkg::ST_DIV: begin
				if (div_cnt_q == dtrn_pkg::DIV_W'(dtrn_pkg::NUM_W - 1)) begin
					state_d = dtrn_pkg::ST_EMIT;
				end
			end
			dtrn_pkg::ST_EMIT: begin
				if (out_acc) begin
					state_d = is_last ? dtrn_pkg::ST_IDLE : dtrn_pkg::ST_FETCH;
				end
			end
			default: state_d = dtrn_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall  = (state_q != dtrn_pkg::ST_IDLE);
		out_valid = (state_q == dtrn_pkg::ST_EMIT);
		scan_rd   = (state_q == dtrn_pkg::ST_SCAN) && (cnt_q < n_q);
		ram_re    = scan_rd || (state_q == dtrn_pkg::ST_FETCH);
		percent   = num_q[dtrn_pkg::PCT_W-1:0];
		last      = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dtrn_pkg::ST_IDLE;
			factor_q  <= dtrn_pkg::FACTOR_W'(1);
			dec_cnt_q <= '0;
			wp_q      <= '0;
			fill_q    <= '0;
			n_q       <= '0;
			cnt_q     <= '0;
			div_cnt_q <= '0;
			rdv_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			rdv_s1  <= scan_rd;
			if (cfg_we) begin
				factor_q <= cfg_wdata;
			end
			if (in_acc && (action == dtrn_pkg::ACT_SAMPLE)) begin
				dec_cnt_q <= store_now ? '0 : dec_inc;
			end
			if (store_now) begin
				wp_q <= wp_inc;
				if (fill_q != dtrn_pkg::FILL_W'(dtrn_pkg::RING_DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (in_acc && (action == dtrn_pkg::ACT_CLEAR)) begin
				wp_q   <= '0;
				fill_q <= '0;
			end
			if (in_acc && (action == dtrn_pkg::ACT_SNAP)) begin
				n_q   <= n_in;
				cnt_q <= '0;
			end
			if (scan_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == dtrn_pkg::ST_SPAN) begin
				cnt_q <= '0;
			end
			if (state_q == dtrn_pkg::ST_LOAD) begin
				div_cnt_q <= '0;
			end
			if (state_q == dtrn_pkg::ST_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (out_acc) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_acc && (action == dtrn_pkg::ACT_SNAP)) begin
			base_q <= base_in;
			ptr_q  <= base_in;
			lo_q   <= dtrn_pkg::FULL_SCALE;
			hi_q   <= '0;
		end
		if (scan_rd || (state_q == dtrn_pkg::ST_FETCH)) begin
			ptr_q <= ptr_inc;
		end
		if (rdv_s1) begin
			if (ram_rdata < lo_q) begin
				lo_q <= ram_rdata;
			end
			if (ram_rdata > hi_q) begin
				hi_q <= ram_rdata;
			end
		end
		if (state_q == dtrn_pkg::ST_SPAN) begin
			span_q <= (hi_q > lo_q) ? (hi_q - lo_q) : dtrn_pkg::SAMPLE_W'(1);
			ptr_q  <= base_q;
		end
		if (state_q == dtrn_pkg::ST_LOAD) begin
			num_q <= dtrn_pkg::NUM_W'(diff) * dtrn_pkg::NUM_W'(dtrn_pkg::PCT_SCALE);
			rem_q <= '0;
		end
		if (state_q == dtrn_pkg::ST_DIV) begin
			num_q <= {num_q[dtrn_pkg::NUM_W-2:0], q_bit};
			rem_q <= rem_sub[dtrn_pkg::SAMPLE_W-1:0];
		end
	end

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (percent <= dtrn_pkg::PCT_SCALE))
		else $error("percent above full scale");

	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("result shown while input open");

	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= dtrn_pkg::FILL_W'(dtrn_pkg::RING_DEPTH))
		else $error("fill count past ring depth");

	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last) |=> (state_q == dtrn_pkg::ST_IDLE))
		else $error("snapshot run did not end after last");

endmodule
